/* rtl/core/msp_pkg.sv */
// Shared constants, codes, types and helpers of the partitioned multi-stack memory.
package msp_pkg;

   // Sizing
   localparam int NUM_STACKS = 4;
   localparam int DEPTH      = 128;
   localparam int WORD_BITS  = 32;
   localparam int ADDR_BITS  = $clog2(DEPTH);
   localparam int POS_BITS   = $clog2(DEPTH + 1);
   localparam int FILL_BITS  = POS_BITS;
   localparam int SEL_BITS   = 2;
   localparam int COUNT_BITS = 3;
   localparam int BASE_BITS  = 8;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 8;
   localparam int STATUS_BITS   = 2;

   // Opcodes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // Status codes
   localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_UNDERFLOW = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_BAD_STACK = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_STACK_COUNT = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BASE_ONE    = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BASE_TWO    = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BASE_THREE  = 2'd3;

   // Register reset values
   localparam logic [COUNT_BITS-1:0] RST_STACK_COUNT = 3'd4;
   localparam logic [BASE_BITS-1:0]  RST_BASE_ONE    = 8'd32;
   localparam logic [BASE_BITS-1:0]  RST_BASE_TWO    = 8'd64;
   localparam logic [BASE_BITS-1:0]  RST_BASE_THREE  = 8'd96;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // latch the request fields
      logic execute;   // check, update fill level, access the word store
   } msp_cmd_type;

   // Limit a base register to the memory depth
   function automatic logic [POS_BITS-1:0] clamp_base(input logic [BASE_BITS-1:0] b);
      if (int'(b) > DEPTH) begin
         return POS_BITS'(DEPTH);
      end
      return POS_BITS'(b);
   endfunction

endpackage

/* rtl/core/multi_stack_partitioned_memory.sv */
// Top level: several LIFO stacks in one partitioned word memory.
// Response: the response strobe is high in the cycle after the execute cycle.
// Flow: the execute cycle (fill-level update and the single word-store access) keeps busy
// high, and the next start is taken during the response.
// Reset: synchronous, active high; all stacks empty, registers at their defaults, no clearing pass.
module multi_stack_partitioned_memory
   import msp_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_opcode,
   input  logic [SEL_BITS-1:0]          req_stack_sel,
   input  logic signed [WORD_BITS-1:0]  req_push_value,
   output logic                         rsp_strobe,
   output logic [STATUS_BITS-1:0]       rsp_status,
   output logic signed [WORD_BITS-1:0]  rsp_pop_value,
   input  logic                         csr_we,
   input  logic [CSR_IDX_BITS-1:0]      csr_index,
   input  logic [CSR_DATA_BITS-1:0]     csr_wdata
);

   // The receiver cannot stall: each response is on the ports for exactly one cycle.
   msp_cmd_type cmd;

   msp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   msp_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_opcode     (req_opcode),
      .req_stack_sel  (req_stack_sel),
      .req_push_value (req_push_value),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_status     (rsp_status),
      .rsp_pop_value  (rsp_pop_value)
   );

endmodule

/* rtl/core/msp_ctrl.sv */
// Controller state machine: sequences request capture, execution and response.
module msp_ctrl
   import msp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output logic        rsp_strobe,
   output msp_cmd_type cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EXEC  = 2'd1;
   localparam logic [1:0] S_REPLY = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       take;

   // Accept a new transfer whenever no request is being executed
   assign busy       = (state_ff == S_EXEC);
   assign take       = start && !busy;
   assign rsp_strobe = (state_ff == S_REPLY);

   assign cmd.capture = take;
   assign cmd.execute = (state_ff == S_EXEC);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (take) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_REPLY;
         end
         S_REPLY: begin
            state_in = take ? S_EXEC : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_accept_executes: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> cmd.execute)
      else $error("accepted transfer not executed next cycle");

   a_execute_replies: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> (rsp_strobe && !cmd.execute))
      else $error("execution not followed by a response");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for more than one cycle");

   a_reply_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(cmd.execute))
      else $error("response without an executed request");
`endif

endmodule

/* rtl/core/msp_datapath.sv */
// Datapath: configuration registers, fill levels, word store and result registers.
module msp_datapath
   import msp_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  msp_cmd_type                     cmd,
   input  logic                            req_opcode,
   input  logic [SEL_BITS-1:0]             req_stack_sel,
   input  logic signed [WORD_BITS-1:0]     req_push_value,
   input  logic                            csr_we,
   input  logic [CSR_IDX_BITS-1:0]         csr_index,
   input  logic [CSR_DATA_BITS-1:0]        csr_wdata,
   output logic [STATUS_BITS-1:0]          rsp_status,
   output logic signed [WORD_BITS-1:0]     rsp_pop_value
);

   // Configuration
   logic [COUNT_BITS-1:0] stack_count_ff;
   logic [BASE_BITS-1:0]  base_one_ff;
   logic [BASE_BITS-1:0]  base_two_ff;
   logic [BASE_BITS-1:0]  base_three_ff;

   // Request capture
   logic                  op_ff;
   logic [SEL_BITS-1:0]   sel_ff;
   logic [WORD_BITS-1:0]  val_ff;

   // Stack state
   logic [FILL_BITS-1:0]  fill_ff [NUM_STACKS];
   logic [WORD_BITS-1:0]  mem [DEPTH];

   // Result
   logic [STATUS_BITS-1:0] status_ff;
   logic                   pop_ok_ff;
   logic [WORD_BITS-1:0]   rd_data_ff;

   // Execution decode
   logic [COUNT_BITS-1:0]  count;
   logic                   sel_ok;
   logic                   last_sel;
   logic [POS_BITS-1:0]    start_pos;
   logic [POS_BITS-1:0]    end_pos;
   logic [POS_BITS-1:0]    next_start;
   logic [FILL_BITS-1:0]   room;
   logic [FILL_BITS-1:0]   fill;
   logic                   push_ok;
   logic                   pop_ok;
   logic [ADDR_BITS-1:0]   addr;
   logic [STATUS_BITS-1:0] status_in;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stack_count_ff <= RST_STACK_COUNT;
         base_one_ff    <= RST_BASE_ONE;
         base_two_ff    <= RST_BASE_TWO;
         base_three_ff  <= RST_BASE_THREE;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STACK_COUNT: stack_count_ff <= csr_wdata[COUNT_BITS-1:0];
            CSR_BASE_ONE:    base_one_ff    <= csr_wdata[BASE_BITS-1:0];
            CSR_BASE_TWO:    base_two_ff    <= csr_wdata[BASE_BITS-1:0];
            CSR_BASE_THREE:  base_three_ff  <= csr_wdata[BASE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Latch the request fields on a transfer
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_opcode;
         sel_ff <= req_stack_sel;
         val_ff <= req_push_value;
      end
   end

   // Region bounds of the selected stack
   always_comb begin
      count = (int'(stack_count_ff) > NUM_STACKS) ? COUNT_BITS'(NUM_STACKS) : stack_count_ff;
      sel_ok   = ({1'b0, sel_ff} < count);
      last_sel = ((COUNT_BITS'(sel_ff) + COUNT_BITS'(1)) >= count);
      case (sel_ff)
         2'd0: begin
            start_pos  = '0;
            next_start = clamp_base(base_one_ff);
         end
         2'd1: begin
            start_pos  = clamp_base(base_one_ff);
            next_start = clamp_base(base_two_ff);
         end
         2'd2: begin
            start_pos  = clamp_base(base_two_ff);
            next_start = clamp_base(base_three_ff);
         end
         default: begin
            start_pos  = clamp_base(base_three_ff);
            next_start = POS_BITS'(DEPTH);
         end
      endcase
      end_pos = last_sel ? POS_BITS'(DEPTH) : next_start;
      room    = (end_pos > start_pos) ? FILL_BITS'(end_pos - start_pos) : '0;
      fill    = fill_ff[sel_ff];
      push_ok = sel_ok && (op_ff == OP_PUSH) && (fill < room);
      pop_ok  = sel_ok && (op_ff == OP_POP) && (fill != '0);
      if (op_ff == OP_PUSH) begin
         addr = ADDR_BITS'(start_pos + fill);
      end else begin
         addr = ADDR_BITS'(start_pos + fill - FILL_BITS'(1));
      end
      if (!sel_ok) begin
         status_in = ST_BAD_STACK;
      end else if (op_ff == OP_PUSH) begin
         status_in = push_ok ? ST_OK : ST_OVERFLOW;
      end else begin
         status_in = pop_ok ? ST_OK : ST_UNDERFLOW;
      end
   end

   // Advance or drop the fill level of the selected stack
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STACKS; i++) begin
            fill_ff[i] <= '0;
         end
      end else if (cmd.execute) begin
         if (push_ok) begin
            fill_ff[sel_ff] <= fill + FILL_BITS'(1);
         end else if (pop_ok) begin
            fill_ff[sel_ff] <= fill - FILL_BITS'(1);
         end
      end
   end

   // Word store: one write or one registered read per execution
   always_ff @(posedge clock) begin
      if (cmd.execute && push_ok) begin
         mem[addr] <= val_ff;
      end
      if (cmd.execute && pop_ok) begin
         rd_data_ff <= mem[addr];
      end
   end

   // Hold the result for the response cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= ST_OK;
         pop_ok_ff <= 1'b0;
      end else if (cmd.execute) begin
         status_ff <= status_in;
         pop_ok_ff <= pop_ok;
      end
   end

   assign rsp_status    = status_ff;
   assign rsp_pop_value = pop_ok_ff ? rd_data_ff : '0;

endmodule
